// ===== hw/rtl/scd_pkg.sv =====
// Shared types and constants for the stepper command deframer.
// Used by scd_parser and stepper_command_deframer; depends on nothing.
package scd_pkg;

  // One byte of a packet, as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
    logic [7:0] packet_length;
  } in_word_t;

  // One decoded motion command.
  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        speed;
    logic signed [31:0] accel;
    logic signed [31:0] steps;
  } out_word_t;

  // Command codes on the result channel.
  localparam logic [1:0] CMD_TEST     = 2'd0;
  localparam logic [1:0] CMD_POSITION = 2'd1;
  localparam logic [1:0] CMD_SPEED    = 2'd2;
  localparam logic [1:0] CMD_SEGMENT  = 2'd3;

  // Key whose payload is being gathered.
  typedef enum logic [1:0] {
    PEND_NONE     = 2'd0,
    PEND_POSITION = 2'd1,
    PEND_SPEED    = 2'd2,
    PEND_SEGMENT  = 2'd3
  } pend_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROUTE_END = 3'd0;
  localparam logic [2:0] REG_TEST_KEY  = 3'd1;
  localparam logic [2:0] REG_POS_KEY   = 3'd2;
  localparam logic [2:0] REG_SPEED_KEY = 3'd3;
  localparam logic [2:0] REG_SEG_KEY   = 3'd4;

  // Configuration values handed to the parser.
  typedef struct packed {
    logic [7:0] route_end_byte;
    logic [7:0] test_key;
    logic [7:0] position_key;
    logic [7:0] speed_key;
    logic [7:0] segment_key;
  } keys_t;

  localparam int unsigned NUM_WORDS = 3;

endpackage

// ===== hw/rtl/scd_parser.sv =====
// Packet parser state and the one-byte decode step of the deframer.
// Depends on scd_pkg.
module scd_parser
  import scd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  in_word_t  word,
  input  keys_t     keys,
  output logic      emit,
  output out_word_t result
);

  logic        inside_r,  inside_nxt;
  logic [7:0]  pos_r,     pos_nxt;
  logic [7:0]  len_r,     len_nxt;
  pend_t       pend_r,    pend_nxt;
  logic [3:0]  left_r,    left_nxt;
  logic [31:0] words_r [NUM_WORDS];
  logic [31:0] words_nxt [NUM_WORDS];

  logic [7:0]  pos_eff;
  logic        inside_eff;
  pend_t       pend_eff;
  logic [3:0]  left_eff;
  logic [7:0]  rem;
  logic [3:0]  total;
  logic [3:0]  k;
  logic [1:0]  w;
  logic [3:0]  left_dec;

  always_comb begin
    inside_eff = word.packet_start ? 1'b0 : inside_r;
    pos_eff    = word.packet_start ? 8'd0 : pos_r;
    len_nxt    = word.packet_start ? word.packet_length : len_r;
    pend_eff   = word.packet_start ? PEND_NONE : pend_r;
    left_eff   = word.packet_start ? 4'd0 : left_r;

    inside_nxt = inside_eff;
    pos_nxt    = pos_eff;
    pend_nxt   = pend_eff;
    left_nxt   = left_eff;
    for (int i = 0; i < NUM_WORDS; i++) words_nxt[i] = words_r[i];
    emit       = 1'b0;
    result     = '0;

    rem      = len_nxt - 8'd1 - pos_eff;
    total    = (pend_eff == PEND_SEGMENT) ? 4'd12 : 4'd4;
    k        = total - left_eff;
    w        = k[3:2];
    left_dec = left_eff - 4'd1;

    if (pos_eff < len_nxt) begin
      pos_nxt = pos_eff + 8'd1;
      if (!inside_eff) begin
        if (word.data_byte == keys.route_end_byte) inside_nxt = 1'b1;
      end else if (pend_eff != PEND_NONE) begin
        if (left_eff == 4'd0 || left_eff > total) begin
          pend_nxt = PEND_NONE;
          left_nxt = 4'd0;
        end else begin
          for (int i = 0; i < NUM_WORDS; i++) begin
            if (w == 2'(i)) words_nxt[i] = {words_r[i][23:0], word.data_byte};
          end
          left_nxt = left_dec;
          if (left_dec == 4'd0) begin
            pend_nxt = PEND_NONE;
            emit     = 1'b1;
            case (pend_eff)
              PEND_POSITION: begin
                result.command = CMD_POSITION;
                result.steps   = words_nxt[0];
              end
              PEND_SPEED: begin
                result.command = CMD_SPEED;
                result.speed   = words_nxt[0];
              end
              default: begin
                result.command = CMD_SEGMENT;
                result.speed   = words_nxt[0];
                result.accel   = words_nxt[1];
                result.steps   = words_nxt[2];
              end
            endcase
          end
        end
      end else begin
        // Key byte. Earlier keys win when registers hold equal values.
        if (word.data_byte == keys.test_key) begin
          emit           = 1'b1;
          result.command = CMD_TEST;
        end else if (word.data_byte == keys.position_key) begin
          if (rem >= 8'd4) begin
            pend_nxt = PEND_POSITION;
            left_nxt = 4'd4;
          end
        end else if (word.data_byte == keys.speed_key) begin
          if (rem >= 8'd4) begin
            pend_nxt = PEND_SPEED;
            left_nxt = 4'd4;
          end
        end else if (word.data_byte == keys.segment_key) begin
          if (rem >= 8'd12) begin
            pend_nxt = PEND_SEGMENT;
            left_nxt = 4'd12;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      pos_r    <= 8'd0;
      len_r    <= 8'd0;
      pend_r   <= PEND_NONE;
      left_r   <= 4'd0;
    end else if (advance) begin
      inside_r <= inside_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      pend_r   <= pend_nxt;
      left_r   <= left_nxt;
    end
  end

  // Payload words need no reset: every emitted word is fully shifted in first.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < NUM_WORDS; i++) words_r[i] <= words_nxt[i];
    end
  end

endmodule

// ===== hw/rtl/stepper_command_deframer.sv =====
// Stepper command deframer: input word register, parser and output buffer.
// Depends on scd_pkg and scd_parser.
// A command is registered in the output buffer once the parser decodes its last byte.
// Throughput: one byte per cycle; the parser decodes one byte per cycle.
// The input stalls only while the two-entry output buffer is full.
// Reset (synchronous, rst_n low) empties all stages, clears the parse state and
// restores the configuration registers to their default keys.
module stepper_command_deframer
  import scd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,

  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,

  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,

  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  // Configuration registers. Writes to indexes past the list are dropped.
  keys_t keys_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r.route_end_byte <= 8'd255;
      keys_r.test_key       <= 8'd127;
      keys_r.position_key   <= 8'd11;
      keys_r.speed_key      <= 8'd12;
      keys_r.segment_key    <= 8'd13;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROUTE_END: keys_r.route_end_byte <= cfg_wdata;
        REG_TEST_KEY:  keys_r.test_key       <= cfg_wdata;
        REG_POS_KEY:   keys_r.position_key   <= cfg_wdata;
        REG_SPEED_KEY: keys_r.speed_key      <= cfg_wdata;
        REG_SEG_KEY:   keys_r.segment_key    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input word register. The held word is decoded when the output buffer has
  // a free entry, which is whenever the skid entry is empty.
  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      skid_valid_r;
  logic      advance;
  logic      in_take;

  assign advance  = s1_valid_r && !skid_valid_r;
  assign in_stall = s1_valid_r && skid_valid_r;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_word_r <= in_data;
  end

  // Parser: all state changes and the optional command for one byte.
  logic      emit;
  out_word_t result;

  scd_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance),
    .word   (s1_word_r),
    .keys   (keys_r),
    .emit   (emit),
    .result (result)
  );

  // Output register plus skid entry. A new command goes straight to the
  // output register when that is free or being drained this cycle, and
  // otherwise parks in the skid entry.
  logic      out_valid_r;
  out_word_t out_r;
  out_word_t skid_r;
  logic      out_take;
  logic      produce;

  assign out_take = out_valid_r && !out_stall;
  assign produce  = advance && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) skid_valid_r <= 1'b0;
    end else if (produce) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) out_r <= skid_r;
    end else if (produce) begin
      if (!out_valid_r || out_take) begin
        out_r <= result;
      end else begin
        skid_r <= result;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
